// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, suspended while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen on a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/sacl_pkg.sv -----
// ----------------------------------------------------------------------------
// sacl_pkg
// shared types and constants of the set-associative cache tag lookup
// ----------------------------------------------------------------------------
package sacl_pkg;

	localparam int MAX_SETS  = 256;
	localparam int MAX_WAYS  = 8;
	localparam int ADDR_BITS = 32;

	localparam int TAG_W     = 32;
	localparam int AGE_W     = 3;
	localparam int CFG_W     = 4;
	localparam int OUT_WAY_W = 3;
	localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
	localparam int SHIFT_W   = CFG_W + 1;
	// floor of log2 of the set count
	localparam int MAX_IB    = $clog2(MAX_SETS + 1) - 1;

	localparam logic [CFG_W-1:0] RST_OFFSET_BITS = CFG_W'(6);
	localparam logic [CFG_W-1:0] RST_INDEX_BITS  = CFG_W'(6);
	localparam logic [CFG_W-1:0] RST_WAYS_IN_USE = CFG_W'(4);
	localparam logic             RST_REPLACE     = 1'b0;

	typedef enum logic [1:0] {
		REG_OFFSET_BITS  = 2'd0,
		REG_INDEX_BITS   = 2'd1,
		REG_WAYS_IN_USE  = 2'd2,
		REG_REPLACE_MODE = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		MODE_LRU  = 1'b0,
		MODE_FIFO = 1'b1
	} replace_mode_t;

	// one set of the tag store, held as one ram word
	typedef struct packed {
		logic [MAX_WAYS-1:0]            valid;
		logic [MAX_WAYS-1:0]            dirty;
		logic [MAX_WAYS-1:0][AGE_W-1:0] age;
		logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
		logic [WAY_W-1:0]               fptr;
	} row_t;

	typedef struct packed {
		logic [WCNT_W-1:0] ways;
		replace_mode_t     mode;
	} lookup_cfg_t;

	typedef struct packed {
		logic                 hit;
		logic                 evicted;
		logic                 writeback;
		logic [OUT_WAY_W-1:0] way;
	} result_t;

endpackage

// ----- hw/rtl/set_assoc_cache_tag_lookup_core.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_core
// tag store of a set-associative write-back cache with lru or fifo victims
// ----------------------------------------------------------------------------
// An access is taken on a rising edge with start high and busy low. Its
// result passes the lookup stage and the result register and is then on
// the ports for exactly one cycle with done high; there is no back-pressure
// on the result side.
// No new access is taken while one is in its lookup stage (busy high): the
// whole set (all ways with tag, dirty, valid and age, plus the fifo
// pointer) is one word of the tag ram, read in the accept cycle and
// written back in the next cycle. The next read comes after that write, so
// no forwarding is needed. Sets read as empty after reset through one
// flip-flop per set, so no clearing pass is run and accesses are taken
// straight out of reset. Configuration transfers are always taken
// (cfg_ready is tied high) and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_core (
	input  logic                           clk,
	input  logic                           arst_n,

	// access channel
	input  logic                           start,
	output logic                           busy,
	input  logic [sacl_pkg::ADDR_BITS-1:0] address,
	input  logic                           is_write,

	// configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [sacl_pkg::CFG_W-1:0]     cfg_data,

	// result, one cycle per access
	output logic                           done,
	output logic                           hit,
	output logic                           evicted,
	output logic                           writeback,
	output logic [sacl_pkg::OUT_WAY_W-1:0] way_used
);

	localparam int ROW_W = $bits(sacl_pkg::row_t);

	// configuration registers
	logic [sacl_pkg::CFG_W-1:0] offset_bits_q;
	logic [sacl_pkg::CFG_W-1:0] index_bits_q;
	logic [sacl_pkg::CFG_W-1:0] ways_in_use_q;
	sacl_pkg::replace_mode_t    replace_mode_q;

	// address split
	logic [sacl_pkg::CFG_W-1:0]     index_eff;
	logic [sacl_pkg::SHIFT_W-1:0]   tag_shift;
	logic [sacl_pkg::ADDR_BITS-1:0] addr_shifted;
	logic [sacl_pkg::SET_W-1:0]     set_mask;
	logic [sacl_pkg::SET_W-1:0]     set_idx;
	logic [sacl_pkg::TAG_W-1:0]     tag_idx;
	logic                           accept;

	// lookup stage
	logic                       vld_s1;
	logic [sacl_pkg::SET_W-1:0] set_s1;
	logic [sacl_pkg::TAG_W-1:0] tag_s1;
	logic                       wr_s1;

	logic [sacl_pkg::MAX_SETS-1:0] row_init_q;
	logic [ROW_W-1:0]           ram_rdata;
	sacl_pkg::row_t             cur_row;
	sacl_pkg::row_t             new_row;
	sacl_pkg::lookup_cfg_t      lk_cfg;
	sacl_pkg::result_t          lk_res;
	sacl_pkg::result_t          res_q;
	logic                       done_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q  <= sacl_pkg::RST_OFFSET_BITS;
			index_bits_q   <= sacl_pkg::RST_INDEX_BITS;
			ways_in_use_q  <= sacl_pkg::RST_WAYS_IN_USE;
			replace_mode_q <= sacl_pkg::replace_mode_t'(sacl_pkg::RST_REPLACE);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sacl_pkg::REG_OFFSET_BITS: begin
					offset_bits_q <= cfg_data;
				end
				sacl_pkg::REG_INDEX_BITS: begin
					index_bits_q <= cfg_data;
				end
				sacl_pkg::REG_WAYS_IN_USE: begin
					ways_in_use_q <= cfg_data;
				end
				sacl_pkg::REG_REPLACE_MODE: begin
					replace_mode_q <= sacl_pkg::replace_mode_t'(cfg_data[0]);
				end
				default: begin
				end
			endcase
		end
	end

	// way count clamped to one .. built number of ways
	always_comb begin
		if (ways_in_use_q == '0) begin
			lk_cfg.ways = sacl_pkg::WCNT_W'(1);
		end else if (ways_in_use_q > sacl_pkg::CFG_W'(sacl_pkg::MAX_WAYS)) begin
			lk_cfg.ways = sacl_pkg::WCNT_W'(sacl_pkg::MAX_WAYS);
		end else begin
			lk_cfg.ways = sacl_pkg::WCNT_W'(ways_in_use_q);
		end
		lk_cfg.mode = replace_mode_q;
	end

	// set index saturates at the built number of sets
	assign index_eff = (index_bits_q > sacl_pkg::CFG_W'(sacl_pkg::MAX_IB)) ?
	                   sacl_pkg::CFG_W'(sacl_pkg::MAX_IB) : index_bits_q;
	assign tag_shift    = sacl_pkg::SHIFT_W'(offset_bits_q) + sacl_pkg::SHIFT_W'(index_eff);
	assign addr_shifted = address >> offset_bits_q;
	assign set_mask     = ~({sacl_pkg::SET_W{1'b1}} << index_eff);
	assign set_idx      = addr_shifted[sacl_pkg::SET_W-1:0] & set_mask;
	assign tag_idx      = sacl_pkg::TAG_W'(address >> tag_shift);

	assign accept = start && !busy;
	assign busy   = vld_s1;

	// set word: read on accept, written back in the lookup cycle
	sacl_ram #(
		.WIDTH (ROW_W),
		.DEPTH (sacl_pkg::MAX_SETS)
	) u_tag_ram (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (set_s1),
		.wdata (new_row),
		.re    (accept),
		.raddr (set_idx),
		.rdata (ram_rdata)
	);

	// a set never written reads as empty
	assign cur_row = row_init_q[set_s1] ? sacl_pkg::row_t'(ram_rdata) : '0;

	sacl_way_update u_update (
		.cur_row (cur_row),
		.tag     (tag_s1),
		.wr      (wr_s1),
		.cfg     (lk_cfg),
		.new_row (new_row),
		.res     (lk_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			done_q     <= 1'b0;
			row_init_q <= '0;
		end else begin
			vld_s1 <= accept;
			done_q <= vld_s1;
			if (vld_s1) begin
				row_init_q[set_s1] <= 1'b1;
			end
		end
	end

	// payload of the lookup stage and the result
	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= set_idx;
			tag_s1 <= tag_idx;
			wr_s1  <= is_write;
		end
		if (vld_s1) begin
			res_q <= lk_res;
		end
	end

	assign done      = done_q;
	assign hit       = res_q.hit;
	assign evicted   = res_q.evicted;
	assign writeback = res_q.writeback;
	assign way_used  = res_q.way;

endmodule

// ----- hw/rtl/sacl_ram.sv -----
// ----------------------------------------------------------------------------
// sacl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/sacl_way_update.sv -----
// ----------------------------------------------------------------------------
// sacl_way_update
// tag compare, victim choice and new contents of one set
// ----------------------------------------------------------------------------
module sacl_way_update (
	input  sacl_pkg::row_t                cur_row,
	input  logic [sacl_pkg::TAG_W-1:0]    tag,
	input  logic                          wr,
	input  sacl_pkg::lookup_cfg_t         cfg,
	output sacl_pkg::row_t                new_row,
	output sacl_pkg::result_t             res
);

	logic [sacl_pkg::MAX_WAYS-1:0]     in_use;
	logic [sacl_pkg::MAX_WAYS-1:0]     hit_vec;
	logic [sacl_pkg::MAX_WAYS-1:0]     inv_vec;
	logic                              any_hit;
	logic                              any_inv;
	logic [sacl_pkg::WAY_W-1:0]        hit_way;
	logic [sacl_pkg::WAY_W-1:0]        inv_way;
	logic [sacl_pkg::WAY_W-1:0]        lru_way;
	logic [sacl_pkg::AGE_W-1:0]        best_age;
	logic [sacl_pkg::WCNT_W-1:0]       fifo_ptr;
	logic [sacl_pkg::WCNT_W-1:0]       fifo_next;
	logic [sacl_pkg::WAY_W-1:0]        victim;
	logic                              evict;
	logic                              touch;
	logic [sacl_pkg::AGE_W-1:0]        ref_age;

	always_comb begin
		in_use  = '0;
		hit_vec = '0;
		inv_vec = '0;
		for (int v = 0; v < sacl_pkg::MAX_WAYS; v++) begin
			in_use[v]  = (sacl_pkg::WCNT_W'(v) < cfg.ways);
			hit_vec[v] = in_use[v] && cur_row.valid[v] && (cur_row.tag[v] == tag);
			inv_vec[v] = in_use[v] && !cur_row.valid[v];
		end
		any_hit = |hit_vec;
		any_inv = |inv_vec;

		// lowest matching and lowest invalid way
		hit_way = '0;
		inv_way = '0;
		for (int v = sacl_pkg::MAX_WAYS - 1; v >= 0; v--) begin
			if (hit_vec[v]) begin
				hit_way = sacl_pkg::WAY_W'(v);
			end
			if (inv_vec[v]) begin
				inv_way = sacl_pkg::WAY_W'(v);
			end
		end

		// oldest way in use, lowest index on a tie
		best_age = cur_row.age[0];
		lru_way  = '0;
		for (int v = 1; v < sacl_pkg::MAX_WAYS; v++) begin
			if (in_use[v] && (cur_row.age[v] > best_age)) begin
				best_age = cur_row.age[v];
				lru_way  = sacl_pkg::WAY_W'(v);
			end
		end

		// fifo pointer, out-of-range reads as zero
		fifo_ptr = sacl_pkg::WCNT_W'(cur_row.fptr);
		if (fifo_ptr >= cfg.ways) begin
			fifo_ptr = '0;
		end
		fifo_next = fifo_ptr + sacl_pkg::WCNT_W'(1);
		if (fifo_next >= cfg.ways) begin
			fifo_next = '0;
		end

		evict = !any_hit && !any_inv;
		touch = !(!any_hit && any_inv);
		if (any_hit) begin
			victim = hit_way;
		end else if (any_inv) begin
			victim = inv_way;
		end else if (cfg.mode == sacl_pkg::MODE_FIFO) begin
			victim = fifo_ptr[sacl_pkg::WAY_W-1:0];
		end else begin
			victim = lru_way;
		end
		ref_age = cur_row.age[victim];

		new_row = cur_row;
		for (int v = 0; v < sacl_pkg::MAX_WAYS; v++) begin
			if (sacl_pkg::WAY_W'(v) == victim) begin
				new_row.age[v] = '0;
			end else if (in_use[v]) begin
				if (touch) begin
					if (cur_row.age[v] < ref_age) begin
						new_row.age[v] = cur_row.age[v] + sacl_pkg::AGE_W'(1);
					end
				end else if (cur_row.valid[v] && (cur_row.age[v] != '1)) begin
					new_row.age[v] = cur_row.age[v] + sacl_pkg::AGE_W'(1);
				end
			end
		end

		if (any_hit) begin
			new_row.dirty[victim] = cur_row.dirty[victim] | wr;
		end else begin
			new_row.valid[victim] = 1'b1;
			new_row.dirty[victim] = wr;
			new_row.tag[victim]   = tag;
		end
		if (evict && (cfg.mode == sacl_pkg::MODE_FIFO)) begin
			new_row.fptr = fifo_next[sacl_pkg::WAY_W-1:0];
		end

		res.hit       = any_hit;
		res.evicted   = evict;
		res.writeback = evict && cur_row.dirty[victim];
		res.way       = sacl_pkg::OUT_WAY_W'(victim);
	end

endmodule

// ----- hw/rtl/sacl_checker.sv -----
// ----------------------------------------------------------------------------
// sacl_checker
// port-level checks of the cache tag lookup, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sacl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic                           hit,
	input logic                           evicted,
	input logic                           writeback
);

	`ASSERT_CLK(a_accept_busy, clk, arst_n, (start && !busy) |=> (busy && !done), "no busy after accept")
	`ASSERT_CLK(a_accept_done, clk, arst_n, (start && !busy) |-> ##2 done, "result missing after accept")
	`ASSERT_CLK(a_done_after_busy, clk, arst_n, done |-> ($past(busy) && !busy), "result without access")
	`ASSERT_NEVER(a_hit_no_evict, clk, arst_n, done && hit && (evicted || writeback), "hit evicted a line")
	`ASSERT_NEVER(a_wb_needs_evict, clk, arst_n, done && writeback && !evicted, "writeback without eviction")

endmodule

bind set_assoc_cache_tag_lookup_core sacl_checker u_sacl_checker (.*);
